// ===== hw/rtl/cfh_pkg.sv =====
// Shared types, command codes and checksum helpers for the checked command frame handler.
package cfh_pkg;

  localparam int unsigned ModSum   = 255;
  localparam int unsigned SumBytes = 6;

  typedef enum logic [7:0] {
    CMD_NONE     = 8'd0,
    CMD_SLOT_A   = 8'd1,
    CMD_SLOT_B   = 8'd5,
    CMD_WIRELESS = 8'd6,
    CMD_RELAY    = 8'd7,
    CMD_LATCH    = 8'd10
  } cfh_cmd_e;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic [7:0]  payload_a;
    logic [7:0]  payload_b;
    logic [7:0]  payload_c;
    logic [7:0]  payload_d;
    logic [7:0]  argument_byte;
    logic [7:0]  sum_low;
    logic [7:0]  sum_high;
    logic [15:0] report_word_one;
    logic [15:0] report_word_two;
  } cfh_req_t;

  typedef struct packed {
    logic        ack_updated;
    logic [63:0] ack_frame;
    logic [31:0] process_bytes;
    logic [7:0]  slot_kind;
    logic [7:0]  relay_mode;
    logic [7:0]  wireless_mode;
    logic [7:0]  last_command;
    logic        reconfigure_pulse;
  } cfh_rsp_t;

  // Reduce a 16-bit value modulo 255 by end-around folding.
  function automatic logic [7:0] cfh_mod255(input logic [15:0] v);
    logic [8:0] s1;
    logic [8:0] s2;
    s1 = 9'(v[15:8]) + 9'(v[7:0]);
    s2 = 9'(s1[8]) + 9'(s1[7:0]);
    return (s2[7:0] == 8'(ModSum)) ? 8'd0 : s2[7:0];
  endfunction

endpackage

// ===== hw/rtl/cfh_stream_if.sv =====
// Valid/ready stream channel carrying one request or response payload.
interface cfh_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/checked_command_frame_handler.sv =====
// Top level of the checked command frame handler.
//
// Usage: each request on req_i carries one decoded 8-byte command frame plus
// the two current report words. Every request yields exactly one response on
// rsp_o that shows the handler state after that frame: the acknowledge frame,
// stored process bytes, slot/relay/wireless state and the latched command.
// A frame with a zero command byte or a bad Fletcher-16 leaves state alone.
//
// Pipeline: an accepted request is captured in the input register, then its result is
// registered in the result register. Throughput: one request per cycle unless rsp_o
// stalls; the checksum and command decode fit in the single stage between the registers.
//
// Reset clears all stored state and both pipeline valid flags. When the
// receiver holds rsp_o.ready low, the result register holds, the input stage
// fills, and req_i.ready drops until the response is taken.
module checked_command_frame_handler (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfh_stream_if.sink          req_i,
  cfh_stream_if.source        rsp_o
);
  import cfh_pkg::*;

  logic        in_valid_q;
  cfh_req_t    in_q;
  logic        out_valid_q;
  cfh_rsp_t    out_q;
  cfh_rsp_t    out_d;

  logic [7:0]  slot_q, slot_d;
  logic [7:0]  relay_q, relay_d;
  logic [7:0]  wireless_q, wireless_d;
  logic [7:0]  command_q, command_d;
  logic [31:0] process_q, process_d;
  logic [63:0] ack_q, ack_d;

  logic        advance;
  logic        accept;
  logic [15:0] calc_sum;
  logic        sum_ok;
  logic        pulse;

  cfh_fletcher u_fletcher (
    .frame_i (in_q),
    .sum_o   (calc_sum)
  );

  assign advance       = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready   = !in_valid_q || advance;
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  assign sum_ok = (in_q.cmd_byte != CMD_NONE)
               && (calc_sum == {in_q.sum_high, in_q.sum_low});

  always_comb begin
    slot_d     = slot_q;
    relay_d    = relay_q;
    wireless_d = wireless_q;
    command_d  = command_q;
    process_d  = process_q;
    ack_d      = ack_q;
    pulse      = 1'b0;
    if (sum_ok) begin
      ack_d     = {calc_sum, in_q.argument_byte, in_q.report_word_two,
                   in_q.report_word_one, in_q.cmd_byte};
      process_d = {in_q.payload_d, in_q.payload_c, in_q.payload_b, in_q.payload_a};
      if ((in_q.cmd_byte == CMD_SLOT_A || in_q.cmd_byte == CMD_SLOT_B)
          && slot_q != in_q.argument_byte) begin
        slot_d    = in_q.argument_byte;
        command_d = in_q.cmd_byte;
        pulse     = 1'b1;
      end else if (in_q.cmd_byte == CMD_WIRELESS) begin
        command_d  = CMD_WIRELESS;
        wireless_d = in_q.argument_byte;
      end else if (in_q.cmd_byte == CMD_RELAY) begin
        command_d = CMD_RELAY;
        relay_d   = in_q.argument_byte;
      end else if (in_q.cmd_byte == CMD_LATCH) begin
        command_d = CMD_LATCH;
      end
    end
    out_d.ack_updated       = sum_ok;
    out_d.ack_frame         = ack_d;
    out_d.process_bytes     = process_d;
    out_d.slot_kind         = slot_d;
    out_d.relay_mode        = relay_d;
    out_d.wireless_mode     = wireless_d;
    out_d.last_command      = command_d;
    out_d.reconfigure_pulse = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      relay_q     <= '0;
      wireless_q  <= '0;
      command_q   <= '0;
      process_q   <= '0;
      ack_q       <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        slot_q      <= slot_d;
        relay_q     <= relay_d;
        wireless_q  <= wireless_d;
        command_q   <= command_d;
        process_q   <= process_d;
        ack_q       <= ack_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i.payload;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/cfh_fletcher.sv =====
// Combinational Fletcher-16 (modulo 255) over the six leading frame bytes.
module cfh_fletcher (
  input  cfh_pkg::cfh_req_t frame_i,
  output logic [15:0]       sum_o
);
  import cfh_pkg::*;

  logic [15:0] lo_raw;
  logic [15:0] hi_raw;

  // Low sum is the plain byte sum; high sum weights byte k by (6 - k).
  assign lo_raw = 16'(frame_i.cmd_byte) + 16'(frame_i.payload_a) + 16'(frame_i.payload_b)
                + 16'(frame_i.payload_c) + 16'(frame_i.payload_d)
                + 16'(frame_i.argument_byte);

  assign hi_raw = 16'(frame_i.cmd_byte) * 16'(SumBytes)
                + 16'(frame_i.payload_a) * 16'(SumBytes - 1)
                + 16'(frame_i.payload_b) * 16'(SumBytes - 2)
                + 16'(frame_i.payload_c) * 16'(SumBytes - 3)
                + 16'(frame_i.payload_d) * 16'(SumBytes - 4)
                + 16'(frame_i.argument_byte);

  assign sum_o = {cfh_mod255(hi_raw), cfh_mod255(lo_raw)};

endmodule
